FILE: design/tlfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlfp_pkg;

  localparam logic [7:0] KindData   = 8'h00;
  localparam logic [7:0] KindResize = 8'h01;
  localparam logic [31:0] ResizeLen = 32'd4;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    PhType    = 3'b001,
    PhLen     = 3'b010,
    PhPayload = 3'b100
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] cols;
    logic [15:0] rows;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: design/tlfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tlfp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  output tlfp_pkg::res_t     res_o,
  output logic               res_valid_o
);

  tlfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  kind_q, kind_d;
  logic [1:0]  len_cnt_q, len_cnt_d;
  logic [31:0] tot_len_q, tot_len_d;
  logic [31:0] rcvd_q, rcvd_d;
  logic [7:0]  rsz_q [4];
  logic [7:0]  rsz_d [4];
  logic [31:0] rcvd_inc;

  assign rcvd_inc = rcvd_q + 32'd1;

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    len_cnt_d   = len_cnt_q;
    tot_len_d   = tot_len_q;
    rcvd_d      = rcvd_q;
    rsz_d       = rsz_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (phase_q)
        tlfp_pkg::PhLen: begin
          tot_len_d = {tot_len_q[23:0], in_byte_i};
          len_cnt_d = len_cnt_q + 2'd1;
          if (len_cnt_q == 2'd3) begin
            rcvd_d  = '0;
            phase_d = (tot_len_d == 32'd0) ? tlfp_pkg::PhType : tlfp_pkg::PhPayload;
          end
        end
        tlfp_pkg::PhPayload: begin
          if (kind_q == tlfp_pkg::KindData) begin
            res_valid_o = 1'b1;
            res_o.kind  = 1'b0;
            res_o.data  = in_byte_i;
          end else if (kind_q == tlfp_pkg::KindResize && rcvd_q < tlfp_pkg::ResizeLen) begin
            rsz_d[rcvd_q[1:0]] = in_byte_i;
          end
          rcvd_d = rcvd_inc;
          if (rcvd_inc == tot_len_q) begin
            if (kind_q == tlfp_pkg::KindResize && tot_len_q >= tlfp_pkg::ResizeLen) begin
              res_valid_o = 1'b1;
              res_o.kind  = 1'b1;
              res_o.cols  = {rsz_d[0], rsz_d[1]};
              res_o.rows  = {rsz_d[2], rsz_d[3]};
            end
            phase_d = tlfp_pkg::PhType;
          end
        end
        default: begin
          kind_d    = in_byte_i;
          len_cnt_d = '0;
          tot_len_d = '0;
          phase_d   = tlfp_pkg::PhLen;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tlfp_pkg::PhType;
      kind_q    <= '0;
      len_cnt_q <= '0;
      tot_len_q <= '0;
      rcvd_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      len_cnt_q <= len_cnt_d;
      tot_len_q <= tot_len_d;
      rcvd_q    <= rcvd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsz_q <= rsz_d;
  end

endmodule

`default_nettype wire

FILE: design/tlfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tlfp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  tlfp_pkg::res_t         push_data_i,
  input  wire logic              pop_i,
  output tlfp_pkg::res_t         pop_data_o,
  output tlfp_pkg::queue_status_t status_o
);

  tlfp_pkg::res_t mem_q [tlfp_pkg::QueueDepth];
  logic [tlfp_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tlfp_pkg::QueueCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign status_o.full  = (cnt_q == tlfp_pkg::QueueCntW'(tlfp_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + tlfp_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + tlfp_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + tlfp_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - tlfp_pkg::QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/tlfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tlfp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  tlfp_pkg::queue_status_t status_i,
  input  tlfp_pkg::res_t          head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tlfp_pkg::res_t          out_o
);

  logic           valid_q;
  tlfp_pkg::res_t data_q;
  logic           load;

  assign load        = !valid_q || !out_stall_i;
  assign pop_o       = load && !status_i.empty;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/type_length_frame_parser.sv
// type/length/value deframer, one stream byte per input word
// input channel: in_valid_i / in_stall_o with in_byte_i; a word moves when
//   valid is high and stall is low
// output channel: out_valid_o / out_stall_i with out_kind_o (0 data, 1 resize),
//   out_byte_o for data words, out_cols_o / out_rows_o for resize words
// a frame is a type byte, a 4-byte big-endian length and the payload; type 0
//   payload bytes come out one word each, a type 1 frame of length 4 or more
//   gives one resize word after its last byte, other frames give nothing
// throughput: one input byte per cycle while in_stall_o is low; results leave
//   through a 4-entry queue and an output register
// the edge that accepts a byte writes its result into the queue and the next
//   edge loads the output register, which then offers the result when nothing
//   waits ahead of it
// when the receiver stalls, the output word holds and results collect in the
//   queue; in_stall_o rises once the queue is full
// reset clears the parser to awaiting a type byte and empties queue and output
`timescale 1ns / 1ps
`default_nettype none

module type_length_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      out_cols_o,
  output logic [15:0]      out_rows_o
);

  tlfp_pkg::res_t          front_res, head, out_res;
  tlfp_pkg::queue_status_t q_status;
  logic                    front_valid, accept, pop;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  tlfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .res_o       (front_res),
    .res_valid_o (front_valid)
  );

  tlfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_res),
    .pop_i       (pop),
    .pop_data_o  (head),
    .status_o    (q_status)
  );

  tlfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign out_kind_o = out_res.kind;
  assign out_byte_o = out_res.data;
  assign out_cols_o = out_res.cols;
  assign out_rows_o = out_res.rows;

endmodule

`default_nettype wire
